FILE: src/hgpd_pkg.sv
// hgpd_pkg: shared constants, types and helper functions for the guidance pipeline
// no dependencies; imported by every module of the block but hgpd_delay

package hgpd_pkg;

  // command limit and cordic depth defaults
  localparam int MAX_COMMAND   = 9600;
  localparam int CORDIC_STAGES = 16;

  // datapath widths
  localparam int XY_W    = 33;  // cordic x/y, Q.30 with headroom
  localparam int Z_W     = 28;  // cordic angle, Q.24
  localparam int SQ_W    = 62;  // radicand, squared distance in Q.28
  localparam int RT_W    = 31;  // root, distance in Q.14
  localparam int DIV_N_W = 52;  // rounded dividend magnitude
  localparam int DIV_Q_W = 15;  // quotient bits kept before saturation

  // fixed point constants
  localparam logic signed [Z_W-1:0]  PI_Q24      = 28'sd52707179;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [XY_W-1:0] GAIN_K_Q30  = 33'sd652032874;
  localparam logic signed [24:0]     PI_Q20      = 25'sd3294199;
  localparam logic signed [24:0]     TWO_PI_Q20  = 25'sd6588397;
  localparam logic [RT_W-1:0]        POS_LIMIT   = 31'd163840;
  localparam logic [15:0]            SPEED_LIMIT = 16'd2560;
  localparam logic [49:0]            NEAR_SQ     = 50'd2621;

  // register map
  typedef enum logic [1:0] {
    REG_SPEED_KP = 2'd0,
    REG_SPEED_KD = 2'd1,
    REG_TURN_KP  = 2'd2,
    REG_TURN_KD  = 2'd3
  } reg_idx_e;

  // cordic arctangent table, Q.24
  function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = 28'sd13176795;
      1:  r = 28'sd7778716;
      2:  r = 28'sd4110060;
      3:  r = 28'sd2086331;
      4:  r = 28'sd1047214;
      5:  r = 28'sd524117;
      6:  r = 28'sd262123;
      7:  r = 28'sd131069;
      8:  r = 28'sd65536;
      9:  r = 28'sd32768;
      10: r = 28'sd16384;
      11: r = 28'sd8192;
      12: r = 28'sd4096;
      13: r = 28'sd2048;
      14: r = 28'sd1024;
      15: r = 28'sd512;
      16: r = 28'sd256;
      17: r = 28'sd128;
      18: r = 28'sd64;
      19: r = 28'sd32;
      20: r = 28'sd16;
      21: r = 28'sd8;
      22: r = 28'sd4;
      23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // symmetric saturation to the command limit
  function automatic logic signed [15:0] sat_cmd(input logic signed [65:0] v);
    logic signed [15:0] r;
    if (v > 66'(MAX_COMMAND)) r = 16'(MAX_COMMAND);
    else if (v < -66'(MAX_COMMAND)) r = -16'(MAX_COMMAND);
    else r = 16'(v);
    return r;
  endfunction

endpackage

FILE: src/hgpd_delay.sv
// hgpd_delay: shift line that keeps side data in step with the pipeline
// depends on nothing but its parameters

module hgpd_delay #(
  parameter int Width = 1,
  parameter int Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] tap_q [Depth];

  // shift on every pipeline advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int i = 1; i < Depth; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[Depth-1];

endmodule

FILE: src/hgpd_isqrt.sv
// hgpd_isqrt: pipelined integer square root, one root bit per stage
// depends on hgpd_pkg for the radicand and root widths

module hgpd_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [hgpd_pkg::SQ_W-1:0]  value_i,
  output logic [hgpd_pkg::RT_W-1:0]  root_o
);
  import hgpd_pkg::*;

  logic [SQ_W:0]   rem_q [RT_W-1];
  logic [RT_W-1:0] rt_q  [RT_W];

  for (genvar i = 0; i < RT_W; i++) begin : g_stage
    localparam int K = RT_W - 1 - i;
    logic [SQ_W:0]   rem_in;
    logic [RT_W-1:0] rt_in;
    logic [SQ_W:0]   trial;
    logic            take;

    if (i == 0) begin : g_first
      assign rem_in = {1'b0, value_i};
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign rt_in  = rt_q[i-1];
    end

    // (2r + 2^k) * 2^k against the running remainder
    assign trial = ((SQ_W+1)'(rt_in) << (K + 1)) + ((SQ_W+1)'(1) << (2 * K));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) rt_q[i] <= take ? (rt_in | (RT_W'(1) << K)) : rt_in;
    end

    if (i < RT_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) rem_q[i] <= take ? (rem_in - trial) : rem_in;
      end
    end
  end

  assign root_o = rt_q[RT_W-1];

endmodule

FILE: src/hgpd_cordic.sv
// hgpd_cordic: pipelined rotation cordic giving cos and sin of the heading in Q.30
// depends on hgpd_pkg for widths, gain, pi and the arctangent table

module hgpd_cordic #(
  parameter int Stages = hgpd_pkg::CORDIC_STAGES
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [15:0]                psi_i,
  output logic signed [hgpd_pkg::XY_W-1:0]  cos_o,
  output logic signed [hgpd_pkg::XY_W-1:0]  sin_o
);
  import hgpd_pkg::*;

  logic signed [XY_W-1:0] x_q [Stages+1];
  logic signed [XY_W-1:0] y_q [Stages+1];
  logic signed [Z_W-1:0]  z_q [Stages];
  logic                   flip_q [Stages+1];
  logic signed [Z_W-1:0]  z_raw, z_red;
  logic                   flip;
  logic signed [XY_W-1:0] cos_q, sin_q;

  // fold the heading into plus or minus half pi
  always_comb begin
    z_raw = Z_W'(psi_i) <<< 11;
    z_red = z_raw;
    flip  = 1'b0;
    if (z_raw > HALF_PI_Q24) begin
      z_red = z_raw - PI_Q24;
      flip  = 1'b1;
    end else if (z_raw < -HALF_PI_Q24) begin
      z_red = z_raw + PI_Q24;
      flip  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GAIN_K_Q30;
      y_q[0]    <= '0;
      z_q[0]    <= z_red;
      flip_q[0] <= flip;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < Stages; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
    if (i < Stages - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (z_q[i] >= 0) z_q[i+1] <= z_q[i] - atan_q24(i);
          else z_q[i+1] <= z_q[i] + atan_q24(i);
        end
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= flip_q[Stages] ? -x_q[Stages] : x_q[Stages];
      sin_q <= flip_q[Stages] ? -y_q[Stages] : y_q[Stages];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

FILE: src/hgpd_divider.sv
// hgpd_divider: pipelined restoring divider, one quotient bit per stage, overflow flag
// depends on hgpd_pkg for dividend, divisor and quotient widths

module hgpd_divider (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [hgpd_pkg::DIV_N_W-1:0]  num_i,
  input  logic [hgpd_pkg::RT_W-1:0]     den_i,
  output logic [hgpd_pkg::DIV_Q_W-1:0]  quot_o,
  output logic                          ovf_o
);
  import hgpd_pkg::*;

  logic [DIV_N_W-1:0] rem_q [DIV_Q_W];
  logic [RT_W-1:0]    den_q [DIV_Q_W];
  logic [DIV_Q_W-1:0] quo_q [DIV_Q_W+1];
  logic               ovf_q [DIV_Q_W+1];

  // quotient would not fit in the kept bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= num_i[DIV_N_W-1:DIV_Q_W] >= (DIV_N_W-DIV_Q_W)'(den_i);
    end
  end

  for (genvar j = 0; j < DIV_Q_W; j++) begin : g_bit
    localparam int K = DIV_Q_W - 1 - j;
    logic [DIV_N_W-1:0] trial;
    logic               take;
    assign trial = DIV_N_W'(den_q[j]) << K;
    assign take  = rem_q[j] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1] <= take ? (quo_q[j] | (DIV_Q_W'(1) << K)) : quo_q[j];
        ovf_q[j+1] <= ovf_q[j];
      end
    end
    if (j < DIV_Q_W - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= take ? (rem_q[j] - trial) : rem_q[j];
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

  assign quot_o = quo_q[DIV_Q_W];
  assign ovf_o  = ovf_q[DIV_Q_W];

endmodule

FILE: src/holonomic_guidance_pd.sv
// holonomic_guidance_pd: pd position and heading guidance, one word in, one word out
// depends on hgpd_pkg, hgpd_delay, hgpd_isqrt, hgpd_cordic and hgpd_divider
//
//   port group   | dir | word
//   s_axis_*     | in  | target/current position, ground speed, heading, setpoint, yaw rate
//   m_axis_*     | out | forward, side and turn commands, near flag
//   apb (p*)     | in  | speed_kp, speed_kd, turn_kp, turn_kd at 0x0, 0x4, 0x8, 0xc
//
// a word enters every cycle while the output is not stalled; the pipeline depth from a word
// to its result is set by the 31-stage square root and the 15-stage divider in series.
// reset clears the gains and all valid bits; no clearing pass.
// a stall on the output freezes the whole pipeline; s_axis_tready follows it.

module holonomic_guidance_pd #(
  parameter int CordicStages = hgpd_pkg::CORDIC_STAGES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // apb configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input words
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_north, target_east, here_north, here_east (24 each),
  // ground_speed, yaw_angle, yaw_target, yaw_rate (16 each)
  input  logic [159:0] s_axis_tdata,
  // result words
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // drive_forward, drive_side, drive_turn (15 each), near_target, 2 zero bits
  output logic [47:0]  m_axis_tdata
);
  import hgpd_pkg::*;

  localparam int Lat      = 58;
  localparam int DlyPos   = CordicStages + 2;
  localparam int DlyBody  = 33 - CordicStages;

  // configuration registers
  logic signed [23:0] speed_kp_q, speed_kd_q, turn_kp_q, turn_kd_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_kp_q <= '0;
      speed_kd_q <= '0;
      turn_kp_q  <= '0;
      turn_kd_q  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_SPEED_KP: speed_kp_q <= pwdata[23:0];
        REG_SPEED_KD: speed_kd_q <= pwdata[23:0];
        REG_TURN_KP:  turn_kp_q  <= pwdata[23:0];
        REG_TURN_KD:  turn_kd_q  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SPEED_KP: prdata = 32'(speed_kp_q);
      REG_SPEED_KD: prdata = 32'(speed_kd_q);
      REG_TURN_KP:  prdata = 32'(turn_kp_q);
      REG_TURN_KD:  prdata = 32'(turn_kd_q);
      default:      prdata = '0;
    endcase
  end

  // pipeline advance and valid bits
  logic           en;
  logic [Lat-1:0] vld_q;

  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end

  // input fields
  logic signed [23:0] tn, te, hn, he;
  logic        [15:0] gs;
  logic signed [15:0] psi, yt, rate;

  assign tn   = s_axis_tdata[23:0];
  assign te   = s_axis_tdata[47:24];
  assign hn   = s_axis_tdata[71:48];
  assign he   = s_axis_tdata[95:72];
  assign gs   = s_axis_tdata[111:96];
  assign psi  = s_axis_tdata[127:112];
  assign yt   = s_axis_tdata[143:128];
  assign rate = s_axis_tdata[159:144];

  // stage 1: errors, clamped speed, wrapped heading error
  logic signed [24:0] dn_q, de_q, e20_q, nrate_q;
  logic signed [19:0] nv_q;
  logic signed [15:0] psi_q;
  logic signed [16:0] ydiff;
  logic signed [24:0] e20_raw, e20_d;
  logic        [15:0] v8;

  always_comb begin
    ydiff   = 17'(yt) - 17'(psi);
    e20_raw = 25'(ydiff) <<< 7;
    e20_d   = e20_raw;
    if (e20_raw > PI_Q20) e20_d = e20_raw - TWO_PI_Q20;
    else if (e20_raw < -PI_Q20) e20_d = e20_raw + TWO_PI_Q20;
    v8 = (gs > SPEED_LIMIT) ? SPEED_LIMIT : gs;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dn_q    <= 25'(tn) - 25'(hn);
      de_q    <= 25'(te) - 25'(he);
      psi_q   <= psi;
      e20_q   <= e20_d;
      nrate_q <= -(25'(rate) <<< 8);
      nv_q    <= -($signed({4'b0, v8}) <<< 6);
    end
  end

  // stages 2 to 5: squares, near test, turn law
  logic        [48:0] dn2_q, de2_q;
  logic        [49:0] sq_q;
  logic               near_q;
  logic signed [48:0] tp_q, td_q;
  logic signed [49:0] tsum_q;
  logic signed [65:0] tmul_q;
  logic signed [15:0] turn_q;
  logic signed [49:0] dn_sq, de_sq;

  assign dn_sq = 50'(dn_q) * 50'(dn_q);
  assign de_sq = 50'(de_q) * 50'(de_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dn2_q  <= 49'(dn_sq);
      de2_q  <= 49'(de_sq);
      tp_q   <= 49'(turn_kp_q) * 49'(e20_q);
      td_q   <= 49'(turn_kd_q) * 49'(nrate_q);
      sq_q   <= 50'(dn2_q) + 50'(de2_q);
      near_q <= (50'(dn2_q) + 50'(de2_q)) <= NEAR_SQ;
      tsum_q <= 50'(tp_q) + 50'(td_q);
      tmul_q <= 66'(tsum_q) * 66'(MAX_COMMAND);
      turn_q <= sat_cmd((tmul_q + (66'sd1 <<< 35)) >>> 36);
    end
  end

  // distance, Q.14
  logic [RT_W-1:0] d14;

  hgpd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .en_i    (en),
    .value_i ({sq_q, 12'b0}),
    .root_o  (d14)
  );

  // heading sine and cosine
  logic signed [XY_W-1:0] cos_w, sin_w;

  hgpd_cordic #(.Stages(CordicStages)) u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .psi_i (psi_q),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  // body frame error
  logic signed [24:0] dn_dly, de_dly;
  logic signed [57:0] p_cn_q, p_se_q, p_ce_q, p_sn_q;
  logic signed [58:0] bx_sum, by_sum;
  logic signed [34:0] bx_q, by_q, bx_dly, by_dly;

  hgpd_delay #(.Width(50), .Depth(DlyPos)) u_dly_pos (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i({dn_q, de_q}),
    .data_o({dn_dly, de_dly})
  );

  assign bx_sum = 59'(p_cn_q) + 59'(p_se_q) + (59'sd1 <<< 23);
  assign by_sum = 59'(p_ce_q) - 59'(p_sn_q) + (59'sd1 <<< 23);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cn_q <= 58'(cos_w) * 58'(dn_dly);
      p_se_q <= 58'(sin_w) * 58'(de_dly);
      p_ce_q <= 58'(cos_w) * 58'(de_dly);
      p_sn_q <= 58'(sin_w) * 58'(dn_dly);
      bx_q   <= 35'(bx_sum >>> 24);
      by_q   <= 35'(by_sum >>> 24);
    end
  end

  hgpd_delay #(.Width(70), .Depth(DlyBody)) u_dly_body (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i({bx_q, by_q}),
    .data_o({bx_dly, by_dly})
  );

  // speed law
  logic signed [19:0] nv_dly;
  logic [RT_W-1:0]    e14;
  logic signed [42:0] sp_q, sd_q;
  logic signed [43:0] sacc_q;
  logic signed [59:0] smul_q;
  logic signed [15:0] spd_q;

  hgpd_delay #(.Width(20), .Depth(33)) u_dly_speed (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i(nv_q),
    .data_o(nv_dly)
  );

  assign e14 = (d14 > POS_LIMIT) ? POS_LIMIT : d14;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_q   <= 43'(speed_kp_q) * 43'($signed({1'b0, e14}));
      sd_q   <= 43'(speed_kd_q) * 43'(nv_dly);
      sacc_q <= 44'(sp_q) + 44'(sd_q);
      smul_q <= 60'(sacc_q) * 60'(MAX_COMMAND);
      spd_q  <= sat_cmd(66'((smul_q + (60'sd1 <<< 29)) >>> 30));
    end
  end

  // scaled axis numerators, magnitudes and rounding offset
  logic [RT_W-1:0]        d14_dly;
  logic signed [50:0]     nx_q, ny_q;
  logic        [50:0]     mx_q, my_q;
  logic                   negx_q, negy_q;
  logic [DIV_N_W-1:0]     uhx_q, uhy_q;
  logic [RT_W-1:0]        d40_q;

  hgpd_delay #(.Width(RT_W), .Depth(6)) u_dly_dist (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i(d14),
    .data_o(d14_dly)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= 51'(spd_q) * 51'(bx_dly);
      ny_q   <= 51'(spd_q) * 51'(by_dly);
      negx_q <= nx_q < 0;
      negy_q <= ny_q < 0;
      mx_q   <= (nx_q < 0) ? 51'(-nx_q) : 51'(nx_q);
      my_q   <= (ny_q < 0) ? 51'(-ny_q) : 51'(ny_q);
      uhx_q  <= DIV_N_W'(mx_q) + DIV_N_W'(d14_dly >> 1);
      uhy_q  <= DIV_N_W'(my_q) + DIV_N_W'(d14_dly >> 1);
      d40_q  <= d14_dly;
    end
  end

  // division by the true distance
  logic [DIV_Q_W-1:0] qx, qy;
  logic               ovfx, ovfy;

  hgpd_divider u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (uhx_q),
    .den_i  (d40_q),
    .quot_o (qx),
    .ovf_o  (ovfx)
  );

  hgpd_divider u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (uhy_q),
    .den_i  (d40_q),
    .quot_o (qy),
    .ovf_o  (ovfy)
  );

  // side data brought level with the divider outputs
  logic               negx_dly, negy_dly, near_dly;
  logic signed [15:0] turn_dly;

  hgpd_delay #(.Width(2), .Depth(17)) u_dly_sign (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i({negx_q, negy_q}),
    .data_o({negx_dly, negy_dly})
  );

  hgpd_delay #(.Width(1), .Depth(54)) u_dly_near (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i(near_q),
    .data_o(near_dly)
  );

  hgpd_delay #(.Width(16), .Depth(52)) u_dly_turn (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i(turn_q),
    .data_o(turn_dly)
  );

  // output register: saturate, restore sign, blank near the target
  logic signed [15:0] magx, magy, fwd_d, side_d;
  logic [47:0]        out_q;

  always_comb begin
    magx   = (ovfx || (16'(qx) > 16'(MAX_COMMAND))) ? 16'(MAX_COMMAND) : 16'(qx);
    magy   = (ovfy || (16'(qy) > 16'(MAX_COMMAND))) ? 16'(MAX_COMMAND) : 16'(qy);
    fwd_d  = near_dly ? '0 : (negx_dly ? -magx : magx);
    side_d = near_dly ? '0 : (negy_dly ? -magy : magy);
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= {2'b0, near_dly, turn_dly[14:0], side_d[14:0], fwd_d[14:0]};
  end

  assign m_axis_tdata = out_q;

endmodule

FILE: src/hgpd_checker.sv
// hgpd_sva: port-level checks on the guidance block, attached by bind
// depends on hgpd_pkg for the command limit; binds to holonomic_guidance_pd

module hgpd_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  import hgpd_pkg::*;

  // translation commands are zero near the target
  a_near_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[45] |-> m_axis_tdata[29:0] == 30'd0)
    else $error("translation command not zero near target");

  // every command within the limit
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[14:0]) <= 15'(MAX_COMMAND) &&
      $signed(m_axis_tdata[14:0]) >= -15'(MAX_COMMAND) &&
      $signed(m_axis_tdata[29:15]) <= 15'(MAX_COMMAND) &&
      $signed(m_axis_tdata[29:15]) >= -15'(MAX_COMMAND) &&
      $signed(m_axis_tdata[44:30]) <= 15'(MAX_COMMAND) &&
      $signed(m_axis_tdata[44:30]) >= -15'(MAX_COMMAND))
    else $error("command beyond limit");

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled word changed");

  // input side open whenever the output is empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind holonomic_guidance_pd hgpd_sva u_hgpd_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/hgpd_checker.sv
// hgpd_checker: watches the word channels and configuration writes of the guidance block,
// predicts each result word and compares it field by field; depends on hgpd_pkg

`timescale 1ns / 1ps

module hgpd_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending_count,
  output int           result_count
);
  import hgpd_pkg::*;

  // predictor's own copy of the gains
  longint gain_skp, gain_skd, gain_tkp, gain_tkd;
  logic [47:0] cmd_q[$];

  localparam longint ATAN_TAB[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint shr_round_up(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -(((-v) + h - 1) >>> s);
  endfunction

  function automatic longint div_nearest(longint n, longint d);
    longint u;
    u = (n < 0) ? -n : n;
    u = (u + d / 2) / d;
    return (n < 0) ? -u : u;
  endfunction

  function automatic longint clamp_cmd(longint v);
    if (v > MAX_COMMAND) return MAX_COMMAND;
    if (v < -MAX_COMMAND) return -MAX_COMMAND;
    return v;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // guidance tick for one input word
  function automatic logic [47:0] guidance_cmd(logic [159:0] w);
    longint dn, de, gs, psi, yt, rate, sq, d14, e14, v8, spd, acc, z, x, y, t;
    longint bx, by, fwd, side, turn, e20;
    logic near, flip;
    logic [14:0] f15, s15, t15;
    dn = longint'($signed(w[23:0])) - longint'($signed(w[71:48]));
    de = longint'($signed(w[47:24])) - longint'($signed(w[95:72]));
    gs = longint'(w[111:96]);
    psi = longint'($signed(w[127:112]));
    yt = longint'($signed(w[143:128]));
    rate = longint'($signed(w[159:144]));
    sq = dn * dn + de * de;
    fwd = 0;
    side = 0;
    near = 1'b1;
    if (sq > 2621) begin
      near = 1'b0;
      d14 = root_floor(sq << 12);
      e14 = (d14 > 163840) ? 163840 : d14;
      v8 = (gs > 2560) ? 2560 : gs;
      acc = gain_skp * e14 + gain_skd * (-v8 * 64);
      spd = clamp_cmd(shr_round_up(acc * MAX_COMMAND, 30));
      z = psi * 2048;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 26353589) begin
        z -= 52707179;
        flip = 1'b1;
      end else if (z < -26353589) begin
        z += 52707179;
        flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (z >= 0) begin
          t = x - shr_floor(y, i);
          y = y + shr_floor(x, i);
          z -= ATAN_TAB[i];
        end else begin
          t = x + shr_floor(y, i);
          y = y - shr_floor(x, i);
          z += ATAN_TAB[i];
        end
        x = t;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      bx = shr_round_up(x * dn + y * de, 24);
      by = shr_round_up(x * de - y * dn, 24);
      fwd = clamp_cmd(div_nearest(spd * bx, d14));
      side = clamp_cmd(div_nearest(spd * by, d14));
    end
    e20 = (yt - psi) * 128;
    if (e20 > 3294199) e20 -= 6588397;
    else if (e20 < -3294199) e20 += 6588397;
    acc = gain_tkp * e20 + gain_tkd * (-rate * 256);
    turn = clamp_cmd(shr_round_up(acc * MAX_COMMAND, 36));
    f15 = fwd[14:0];
    s15 = side[14:0];
    t15 = turn[14:0];
    return {2'b00, near, t15, s15, f15};
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got, want);
    fail_count++;
  endtask

  assign pending_count = cmd_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [47:0] exp_w;
    if (!rst_ni) begin
      gain_skp <= 0;
      gain_skd <= 0;
      gain_tkp <= 0;
      gain_tkd <= 0;
      fail_count = 0;
      result_count <= 0;
      cmd_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_SPEED_KP: gain_skp <= longint'($signed(pwdata[23:0]));
          REG_SPEED_KD: gain_skd <= longint'($signed(pwdata[23:0]));
          REG_TURN_KP:  gain_tkp <= longint'($signed(pwdata[23:0]));
          REG_TURN_KD:  gain_tkd <= longint'($signed(pwdata[23:0]));
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) cmd_q.push_back(guidance_cmd(s_axis_tdata));
      // compare result word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        result_count <= result_count + 1;
        if (cmd_q.size() == 0) begin
          report_mismatch("unexpected word", longint'(m_axis_tdata), 0);
        end else begin
          exp_w = cmd_q.pop_front();
          if (m_axis_tdata[14:0] !== exp_w[14:0])
            report_mismatch("drive_forward", $signed(m_axis_tdata[14:0]), $signed(exp_w[14:0]));
          if (m_axis_tdata[29:15] !== exp_w[29:15])
            report_mismatch("drive_side", $signed(m_axis_tdata[29:15]), $signed(exp_w[29:15]));
          if (m_axis_tdata[44:30] !== exp_w[44:30])
            report_mismatch("drive_turn", $signed(m_axis_tdata[44:30]), $signed(exp_w[44:30]));
          if (m_axis_tdata[45] !== exp_w[45])
            report_mismatch("near_target", m_axis_tdata[45], exp_w[45]);
        end
      end
    end
  end
endmodule

FILE: verif/tb_top.sv
// tb_top: stimulus and verdict for holonomic_guidance_pd
// depends on hgpd_pkg, the block and hgpd_checker

`timescale 1ns / 1ps

module tb_top;
  import hgpd_pkg::*;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [159:0] s_axis_tdata;
  logic [47:0] m_axis_tdata;
  int fail_count, pending_count, result_count;
  int send_idle_pct, recv_stall_pct, hold_off;
  longint cycle_count;
  int words_sent;

  holonomic_guidance_pd uut (.*);

  hgpd_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("timeout");
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [23:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {8'h00, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_gains(logic [23:0] skp, logic [23:0] skd, logic [23:0] tkp,
                           logic [23:0] tkd);
    apb_write(REG_SPEED_KP, skp);
    apb_write(REG_SPEED_KD, skd);
    apb_write(REG_TURN_KP, tkp);
    apb_write(REG_TURN_KD, tkd);
  endtask

  // offer one word, random idle gap first, wait for acceptance
  task automatic send_word(logic [23:0] tn, logic [23:0] te, logic [23:0] hn,
                           logic [23:0] he, logic [15:0] gs, logic [15:0] ya,
                           logic [15:0] yt, logic [15:0] yr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {yr, yt, ya, gs, he, hn, te, tn};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // let the last accepted word reach the prediction queue before polling it
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_heading();
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  // mostly nearby targets so distances vary around the clamp and near threshold
  task automatic send_random();
    logic [23:0] hn, he;
    int span;
    hn = $urandom;
    he = $urandom;
    case ($urandom_range(3))
      0: span = 64;
      1: span = 4096;
      2: span = 1 << 16;
      default: span = 1 << 23;
    endcase
    send_word(hn + 24'($signed($urandom_range(2 * span)) - span),
              he + 24'($signed($urandom_range(2 * span)) - span),
              hn, he, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000)),
              ($urandom_range(7) == 0) ? 16'($urandom) : rand_heading(),
              ($urandom_range(7) == 0) ? 16'($urandom) : rand_heading(), 16'($urandom));
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    words_sent = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero gains first, then typical gains
    send_word(24'd1000, 24'd0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    drain();
    set_gains(24'd65536, 24'd16384, 24'd131072, 24'd32768);
    // near threshold: two points just above 0.2 m squared
    send_word(24'd51, 24'd10, 24'd0, 24'd0, 16'd100, 16'd0, 16'd0, 16'd0);
    send_word(24'd51, 24'd11, 24'd0, 24'd0, 16'd100, 16'd0, 16'd0, 16'd0);
    send_word(24'd0, 24'd0, 24'd0, 24'd0, 16'd0, 16'd25736, -16'sd25736, 16'd0);
    // position extremes
    send_word(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 16'hffff, 16'h7fff,
              16'h8000, 16'h7fff);
    send_word(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 16'hffff, 16'h8000,
              16'h7fff, 16'h8000);
    send_word(24'd2560, 24'd0, 24'd0, 24'd0, 16'd2560, 16'd12868, 16'd0, 16'd4096);
    // headings beyond pi and wraps
    send_word(24'd0, 24'd5000, 24'd0, 24'd0, 16'd300, 16'd30000, -16'sd30000, 16'd0);
    send_word(24'd300, -24'sd300, 24'd0, 24'd0, 16'd10, -16'sd30000, 16'd30000, 16'hffff);
    send_word(24'd700, 24'd700, 24'd0, 24'd0, 16'd0, -16'sd12869, 16'd12868, 16'd0);
    drain();
    // extreme gains, all bits toggled
    set_gains(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff);
    send_word(24'd100000, 24'd3, 24'd0, 24'd0, 16'd0, 16'd1, 16'd8000, 16'd1);
    send_word(24'd4, 24'd70, 24'd0, 24'd0, 16'd2561, 16'd0, -16'sd8000, -16'sd1);
    drain();
    set_gains(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
    send_word(-24'sd90000, 24'd70000, 24'd0, 24'd0, 16'd50, 16'd20000, 16'd0, 16'd12345);
    drain();

    // random phases with changing gains
    for (int ph = 0; ph < 8; ph++) begin
      set_gains(24'($urandom_range(3) == 0 ? $urandom : $urandom_range(300000)),
                24'($urandom_range(3) == 0 ? $urandom : $urandom_range(100000)),
                24'($urandom_range(3) == 0 ? $urandom : $urandom_range(300000)),
                24'($urandom_range(3) == 0 ? $urandom : $urandom_range(100000)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph == 2) hold_off = 300;
      for (int k = 0; k < 60; k++) send_random();
      drain();
    end

    $display("covered %0d words, %0d results, near and far targets, heading wraps,",
             words_sent, result_count);
    $display("gain extremes and four idle and stall mixes with one long output hold-off");
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
